// ===== hw/rtl/bdpc_pkg.sv =====
package bdpc_pkg;

   // Width of every timestamp and time difference; time wraps modulo 2**TIME_BITS.
   localparam int TIME_BITS = 32;

   // Width of the threshold registers.
   localparam int CFG_BITS = 16;

   // Width of the register index on the configuration port.
   localparam int CSR_INDEX_BITS = 4;

   typedef logic [TIME_BITS-1:0]      time_type;
   typedef logic [CFG_BITS-1:0]       cfg_word_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   // Register indexes on the configuration port.
   localparam csr_index_type CSR_DEBOUNCE_MS        = csr_index_type'(0);
   localparam csr_index_type CSR_SHORT_PRESS_MAX_MS = csr_index_type'(1);
   localparam csr_index_type CSR_HOLD_SHORT_MS      = csr_index_type'(2);
   localparam csr_index_type CSR_HOLD_LONG_MS       = csr_index_type'(3);

   // Reset values of the threshold registers.
   localparam cfg_word_type DEBOUNCE_MS_RESET        = cfg_word_type'(30);
   localparam cfg_word_type SHORT_PRESS_MAX_MS_RESET = cfg_word_type'(600);
   localparam cfg_word_type HOLD_SHORT_MS_RESET      = cfg_word_type'(2000);
   localparam cfg_word_type HOLD_LONG_MS_RESET       = cfg_word_type'(4000);

   // Event codes reported with every result.
   typedef enum logic [2:0] {
      EV_NONE           = 3'd0,
      EV_SINGLE_PRESS   = 3'd1,
      EV_SET_HOUR       = 3'd2,
      EV_SET_BREAKPOINT = 3'd3,
      EV_SHORT_MARK     = 3'd4,
      EV_LONG_MARK      = 3'd5
   } event_type;

   // Threshold registers as seen by the classifier.
   typedef struct packed {
      cfg_word_type debounce_ms;
      cfg_word_type short_press_max_ms;
      cfg_word_type hold_short_ms;
      cfg_word_type hold_long_ms;
   } cfg_type;

   // One poll beat.
   typedef struct packed {
      time_type now_ms;
      logic     raw_down;
   } poll_type;

   // One result beat.
   typedef struct packed {
      event_type event_res;
      logic      is_pressed;
      time_type  held_time_ms;
   } result_type;

   // Zero-extend a threshold to the time width for comparison.
   function automatic time_type widen_cfg(cfg_word_type value);
      return time_type'(value);
   endfunction

endpackage

// ===== hw/rtl/bdpc_csr.sv =====
module bdpc_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  bdpc_pkg::csr_index_type csr_index,
   input  bdpc_pkg::cfg_word_type csr_data,
   output bdpc_pkg::cfg_type      cfg
);

   bdpc_pkg::cfg_type cfg_ff;
   bdpc_pkg::cfg_type cfg_in;

   // Writes are always taken.
   assign csr_ready = 1'b1;

   // Decode the register index; indexes past the last register are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            bdpc_pkg::CSR_DEBOUNCE_MS:        cfg_in.debounce_ms        = csr_data;
            bdpc_pkg::CSR_SHORT_PRESS_MAX_MS: cfg_in.short_press_max_ms = csr_data;
            bdpc_pkg::CSR_HOLD_SHORT_MS:      cfg_in.hold_short_ms      = csr_data;
            bdpc_pkg::CSR_HOLD_LONG_MS:       cfg_in.hold_long_ms       = csr_data;
            default:                          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= bdpc_pkg::DEBOUNCE_MS_RESET;
         cfg_ff.short_press_max_ms <= bdpc_pkg::SHORT_PRESS_MAX_MS_RESET;
         cfg_ff.hold_short_ms      <= bdpc_pkg::HOLD_SHORT_MS_RESET;
         cfg_ff.hold_long_ms       <= bdpc_pkg::HOLD_LONG_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/bdpc_input_stage.sv =====
module bdpc_input_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  bdpc_pkg::poll_type  req_poll,
   input  logic                result_free,
   output logic                poll_fire,
   output bdpc_pkg::poll_type  poll
);

   logic               valid_ff;
   logic               valid_in;
   bdpc_pkg::poll_type poll_ff;
   logic               accept;

   // The held poll moves on whenever the result register can take its result.
   assign poll_fire = valid_ff && result_free;

   // Stall only when a poll is held and cannot move on this cycle.
   assign req_stall = valid_ff && !result_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (poll_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register loads on every accepted beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         poll_ff <= req_poll;
      end
   end

   assign poll = poll_ff;

endmodule

// ===== hw/rtl/bdpc_core.sv =====
module bdpc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 poll_fire,
   input  bdpc_pkg::poll_type   poll,
   input  bdpc_pkg::cfg_type    cfg,
   output bdpc_pkg::result_type result
);

   logic                raw_previous_ff, raw_previous_in;
   logic                stable_down_ff, stable_down_in;
   bdpc_pkg::time_type  last_change_time_ff, last_change_time_in;
   bdpc_pkg::time_type  press_start_time_ff, press_start_time_in;
   logic                short_mark_sent_ff, short_mark_sent_in;
   logic                long_mark_sent_ff, long_mark_sent_in;

   bdpc_pkg::time_type  since_change;
   bdpc_pkg::time_type  held_old;
   bdpc_pkg::time_type  held_new;
   bdpc_pkg::event_type event_res;
   logic                settled;

   // Time since the last raw change, and hold time from the recorded start.
   assign since_change = poll.now_ms - last_change_time_ff;
   assign held_old     = poll.now_ms - press_start_time_ff;
   assign settled      = since_change >= bdpc_pkg::widen_cfg(cfg.debounce_ms);

   // Debounce, press tracking and event selection for one poll.
   always_comb begin
      raw_previous_in     = raw_previous_ff;
      stable_down_in      = stable_down_ff;
      last_change_time_in = last_change_time_ff;
      press_start_time_in = press_start_time_ff;
      short_mark_sent_in  = short_mark_sent_ff;
      long_mark_sent_in   = long_mark_sent_ff;
      event_res           = bdpc_pkg::EV_NONE;
      priority if (poll.raw_down != raw_previous_ff) begin
         // Raw level moved: restart the settle timer.
         raw_previous_in     = poll.raw_down;
         last_change_time_in = poll.now_ms;
      end else if (!settled) begin
         event_res = bdpc_pkg::EV_NONE;
      end else if (poll.raw_down != stable_down_ff) begin
         stable_down_in = poll.raw_down;
         if (poll.raw_down) begin
            // Debounced press: record its start and rearm both marks.
            press_start_time_in = poll.now_ms;
            short_mark_sent_in  = 1'b0;
            long_mark_sent_in   = 1'b0;
         end else begin
            // Debounced release: classify the hold time.
            press_start_time_in = '0;
            priority if (held_old < bdpc_pkg::widen_cfg(cfg.short_press_max_ms)) begin
               event_res = bdpc_pkg::EV_SINGLE_PRESS;
            end else if (held_old >= bdpc_pkg::widen_cfg(cfg.hold_long_ms)) begin
               event_res = bdpc_pkg::EV_SET_HOUR;
            end else if (held_old >= bdpc_pkg::widen_cfg(cfg.hold_short_ms)) begin
               event_res = bdpc_pkg::EV_SET_BREAKPOINT;
            end else begin
               event_res = bdpc_pkg::EV_NONE;
            end
         end
      end else if (stable_down_ff && (press_start_time_ff != '0)) begin
         // Still held: at most one mark per poll, short before long.
         priority if (!short_mark_sent_ff &&
                      held_old >= bdpc_pkg::widen_cfg(cfg.hold_short_ms)) begin
            short_mark_sent_in = 1'b1;
            event_res          = bdpc_pkg::EV_SHORT_MARK;
         end else if (!long_mark_sent_ff &&
                      held_old >= bdpc_pkg::widen_cfg(cfg.hold_long_ms)) begin
            long_mark_sent_in = 1'b1;
            event_res         = bdpc_pkg::EV_LONG_MARK;
         end else begin
            event_res = bdpc_pkg::EV_NONE;
         end
      end else begin
         event_res = bdpc_pkg::EV_NONE;
      end
   end

   // Held time reported after this poll's update.
   assign held_new = poll.now_ms - press_start_time_in;

   always_comb begin
      result.event_res    = event_res;
      result.is_pressed   = stable_down_in;
      result.held_time_ms = (stable_down_in && (press_start_time_in != '0)) ? held_new : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_previous_ff     <= 1'b0;
         stable_down_ff      <= 1'b0;
         last_change_time_ff <= '0;
         press_start_time_ff <= '0;
         short_mark_sent_ff  <= 1'b0;
         long_mark_sent_ff   <= 1'b0;
      end else if (poll_fire) begin
         raw_previous_ff     <= raw_previous_in;
         stable_down_ff      <= stable_down_in;
         last_change_time_ff <= last_change_time_in;
         press_start_time_ff <= press_start_time_in;
         short_mark_sent_ff  <= short_mark_sent_in;
         long_mark_sent_ff   <= long_mark_sent_in;
      end
   end

   // The long mark is sent at most once per press.
   a_long_mark_once: assert property (@(posedge clock) disable iff (reset)
      (poll_fire && event_res == bdpc_pkg::EV_LONG_MARK) |-> !long_mark_sent_ff)
      else $error("long mark sent twice for one press");

   // Hold marks only come while a press with a nonzero start is held.
   a_mark_while_held: assert property (@(posedge clock) disable iff (reset)
      (poll_fire && (event_res == bdpc_pkg::EV_SHORT_MARK ||
                     event_res == bdpc_pkg::EV_LONG_MARK))
      |-> (stable_down_ff && press_start_time_ff != '0))
      else $error("hold mark without a held press");

   // Release classifications only come with a released button.
   a_release_state: assert property (@(posedge clock) disable iff (reset)
      (poll_fire && (event_res == bdpc_pkg::EV_SINGLE_PRESS ||
                     event_res == bdpc_pkg::EV_SET_HOUR ||
                     event_res == bdpc_pkg::EV_SET_BREAKPOINT))
      |=> (!stable_down_ff && press_start_time_ff == '0))
      else $error("release event while still pressed");

endmodule

// ===== hw/rtl/bdpc_output_stage.sv =====
module bdpc_output_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 poll_fire,
   input  bdpc_pkg::result_type result,
   output logic                 result_free,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output bdpc_pkg::result_type rsp_result
);

   logic                 valid_ff;
   logic                 valid_in;
   bdpc_pkg::result_type result_ff;

   // The register can load when it is empty or its beat leaves this cycle.
   assign result_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (poll_fire) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (poll_fire) begin
         result_ff <= result;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== hw/rtl/button_debounce_press_classifier_top.sv =====
// Button debouncer and press classifier. Each poll beat carries a millisecond
// timestamp and the raw button level and yields exactly one result beat with an
// event code, the debounced state and the time held so far. A poll passes through
// an input register, compare-and-update logic against the debounce and press
// state, and a result register, so one poll is taken every clock cycle while the
// output is not stalled, and its result is offered on the result port once the
// result register holds it. A stall on the result side backs up into the input
// side only once both registers are full. The user must write thresholds through
// the csr port only while no poll is in flight; the block does not enforce it.
// Indexes above 3 are ignored. A press that begins at timestamp zero receives no
// hold marks and reports a held time of zero.
module button_debounce_press_classifier_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  bdpc_pkg::time_type      req_now_ms,
   input  logic                    req_raw_down,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bdpc_pkg::event_type     rsp_event_res,
   output logic                    rsp_is_pressed,
   output bdpc_pkg::time_type      rsp_held_time_ms,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  bdpc_pkg::csr_index_type csr_index,
   input  bdpc_pkg::cfg_word_type  csr_data
);

   bdpc_pkg::cfg_type    cfg;
   bdpc_pkg::poll_type   req_poll;
   bdpc_pkg::poll_type   poll;
   bdpc_pkg::result_type result;
   bdpc_pkg::result_type rsp_result;
   logic                 result_free;
   logic                 poll_fire;

   assign req_poll.now_ms   = req_now_ms;
   assign req_poll.raw_down = req_raw_down;

   bdpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   bdpc_input_stage u_input_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_poll    (req_poll),
      .result_free (result_free),
      .poll_fire   (poll_fire),
      .poll        (poll)
   );

   bdpc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .poll_fire (poll_fire),
      .poll      (poll),
      .cfg       (cfg),
      .result    (result)
   );

   bdpc_output_stage u_output_stage (
      .clock       (clock),
      .reset       (reset),
      .poll_fire   (poll_fire),
      .result      (result),
      .result_free (result_free),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_result  (rsp_result)
   );

   assign rsp_event_res    = rsp_result.event_res;
   assign rsp_is_pressed   = rsp_result.is_pressed;
   assign rsp_held_time_ms = rsp_result.held_time_ms;

endmodule

// ===== bench/bdpc_checker.sv =====
// Watches the poll, result and register channels of the button classifier.
// Predicts one result per accepted poll and compares each result beat with the
// oldest prediction still waiting.
module bdpc_checker (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  bdpc_pkg::time_type      req_now_ms,
   input  logic                    req_raw_down,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  bdpc_pkg::event_type     rsp_event_res,
   input  logic                    rsp_is_pressed,
   input  bdpc_pkg::time_type      rsp_held_time_ms,
   input  logic                    csr_valid,
   input  logic                    csr_ready,
   input  bdpc_pkg::csr_index_type csr_index,
   input  bdpc_pkg::cfg_word_type  csr_data,
   output int                      mismatch_count,
   output int                      outstanding
);

   // Threshold registers as the block should hold them.
   bdpc_pkg::cfg_type thr;

   // Debounce and press state of the prediction.
   logic               level_seen;
   logic               debounced;
   bdpc_pkg::time_type settle_start;
   bdpc_pkg::time_type press_origin;
   logic               short_done;
   logic               long_done;

   bdpc_pkg::result_type awaited_results[$];
   int                   misses;

   // Works out the result of one poll and advances the predicted state.
   function automatic bdpc_pkg::result_type classify_poll(bdpc_pkg::time_type now,
                                                          logic raw);
      bdpc_pkg::result_type r;
      bdpc_pkg::time_type   held;
      r.event_res = bdpc_pkg::EV_NONE;
      if (raw != level_seen) begin
         // A change of the raw level only restarts the settle timer.
         level_seen   = raw;
         settle_start = now;
      end else if (bdpc_pkg::time_type'(now - settle_start) >=
                   bdpc_pkg::time_type'(thr.debounce_ms)) begin
         if (raw != debounced) begin
            debounced = raw;
            if (raw) begin
               press_origin = now;
               short_done   = 1'b0;
               long_done    = 1'b0;
            end else begin
               // Release: classify the hold time and forget the start.
               held         = now - press_origin;
               press_origin = '0;
               if (held < bdpc_pkg::time_type'(thr.short_press_max_ms))
                  r.event_res = bdpc_pkg::EV_SINGLE_PRESS;
               else if (held >= bdpc_pkg::time_type'(thr.hold_long_ms))
                  r.event_res = bdpc_pkg::EV_SET_HOUR;
               else if (held >= bdpc_pkg::time_type'(thr.hold_short_ms))
                  r.event_res = bdpc_pkg::EV_SET_BREAKPOINT;
            end
         end else if (debounced && press_origin != '0) begin
            // Still held: at most one mark per poll, short mark first.
            held = now - press_origin;
            if (!short_done && held >= bdpc_pkg::time_type'(thr.hold_short_ms)) begin
               short_done  = 1'b1;
               r.event_res = bdpc_pkg::EV_SHORT_MARK;
            end else if (!long_done && held >= bdpc_pkg::time_type'(thr.hold_long_ms)) begin
               long_done   = 1'b1;
               r.event_res = bdpc_pkg::EV_LONG_MARK;
            end
         end
      end
      r.is_pressed   = debounced;
      r.held_time_ms = (debounced && press_origin != '0) ?
                       bdpc_pkg::time_type'(now - press_origin) : '0;
      return r;
   endfunction

   task automatic report_miss(input string what, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      misses++;
      if (misses <= 10)
         $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
   endtask

   // Register writes, poll beats and result beats, all sampled at the rising edge.
   always @(posedge clock) begin : watch
      bdpc_pkg::result_type oldest;
      if (reset) begin
         thr.debounce_ms        = bdpc_pkg::DEBOUNCE_MS_RESET;
         thr.short_press_max_ms = bdpc_pkg::SHORT_PRESS_MAX_MS_RESET;
         thr.hold_short_ms      = bdpc_pkg::HOLD_SHORT_MS_RESET;
         thr.hold_long_ms       = bdpc_pkg::HOLD_LONG_MS_RESET;
         level_seen   = 1'b0;
         debounced    = 1'b0;
         settle_start = '0;
         press_origin = '0;
         short_done   = 1'b0;
         long_done    = 1'b0;
         awaited_results.delete();
         misses = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bdpc_pkg::CSR_DEBOUNCE_MS:        thr.debounce_ms        = csr_data;
               bdpc_pkg::CSR_SHORT_PRESS_MAX_MS: thr.short_press_max_ms = csr_data;
               bdpc_pkg::CSR_HOLD_SHORT_MS:      thr.hold_short_ms      = csr_data;
               bdpc_pkg::CSR_HOLD_LONG_MS:       thr.hold_long_ms       = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(classify_poll(req_now_ms, req_raw_down));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               misses++;
               if (misses <= 10)
                  $display("result beat with no poll waiting: event %0d pressed %0d held %0d",
                           rsp_event_res, rsp_is_pressed, rsp_held_time_ms);
            end else begin
               oldest = awaited_results.pop_front();
               if (rsp_event_res !== oldest.event_res)
                  report_miss("event_res", 32'(oldest.event_res), 32'(rsp_event_res));
               if (rsp_is_pressed !== oldest.is_pressed)
                  report_miss("is_pressed", 32'(oldest.is_pressed), 32'(rsp_is_pressed));
               if (rsp_held_time_ms !== oldest.held_time_ms)
                  report_miss("held_time_ms", oldest.held_time_ms, rsp_held_time_ms);
            end
         end
      end
      mismatch_count <= misses;
      outstanding    <= awaited_results.size();
   end

endmodule

// ===== bench/tb_button_debounce_press_classifier_top.sv =====
// Drives polls and threshold writes into the button classifier and gives the verdict.
module tb_button_debounce_press_classifier_top;

   localparam int CYCLE_LIMIT      = 600000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 8;
   localparam int IDLE_CYCLES      = 4;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   bdpc_pkg::time_type      req_now_ms;
   logic                    req_raw_down;
   logic                    rsp_valid;
   logic                    rsp_stall;
   bdpc_pkg::event_type     rsp_event_res;
   logic                    rsp_is_pressed;
   bdpc_pkg::time_type      rsp_held_time_ms;
   logic                    csr_valid;
   logic                    csr_ready;
   bdpc_pkg::csr_index_type csr_index;
   bdpc_pkg::cfg_word_type  csr_data;

   int          mismatch_count;
   int          outstanding;
   int unsigned cycle_count = 0;

   // Stimulus bookkeeping: thresholds in force and the poll clock.
   bdpc_pkg::cfg_type  live_cfg;
   bdpc_pkg::time_type wall_ms;
   int unsigned        polls_sent;
   logic               sender_calm;
   logic               receiver_calm;
   logic               hold_off_pending;

   button_debounce_press_classifier_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_ms       (req_now_ms),
      .req_raw_down     (req_raw_down),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_is_pressed   (rsp_is_pressed),
      .rsp_held_time_ms (rsp_held_time_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   bdpc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_now_ms       (req_now_ms),
      .req_raw_down     (req_raw_down),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_is_pressed   (rsp_is_pressed),
      .rsp_held_time_ms (rsp_held_time_ms),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("status: fail");
      $finish;
   end

   // Offers one poll beat after a random gap and returns once it is taken.
   task automatic send_poll(input bdpc_pkg::time_type now, input logic raw);
      int unsigned gap;
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      gap = sender_calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_now_ms   <= now;
      req_raw_down <= raw;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      polls_sent++;
      wall_ms = now;
   endtask

   // One register write beat; the caller lowers csr_valid after its last beat.
   task automatic csr_beat(input bdpc_pkg::csr_index_type idx,
                           input bdpc_pkg::cfg_word_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Stops offering polls, waits for the block to drain, then writes all four
   // thresholds and one index that the block must ignore.
   task automatic set_thresholds(input bdpc_pkg::cfg_word_type debounce,
                                 input bdpc_pkg::cfg_word_type press_max,
                                 input bdpc_pkg::cfg_word_type mark_short,
                                 input bdpc_pkg::cfg_word_type mark_long,
                                 input bdpc_pkg::csr_index_type spare_index);
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_beat(bdpc_pkg::CSR_DEBOUNCE_MS, debounce);
      csr_beat(bdpc_pkg::CSR_SHORT_PRESS_MAX_MS, press_max);
      csr_beat(bdpc_pkg::CSR_HOLD_SHORT_MS, mark_short);
      csr_beat(bdpc_pkg::CSR_HOLD_LONG_MS, mark_long);
      csr_beat(spare_index, bdpc_pkg::cfg_word_type'($urandom));
      csr_valid <= 1'b0;
      live_cfg.debounce_ms        = debounce;
      live_cfg.short_press_max_ms = press_max;
      live_cfg.hold_short_ms      = mark_short;
      live_cfg.hold_long_ms       = mark_long;
   endtask

   // Moves the raw level to the given value with some chatter, then holds it
   // long enough for the debounced state to follow.
   task automatic settle_to(input logic level);
      int unsigned chatter;
      chatter = $urandom_range(0, 3);
      for (int i = 0; i < chatter; i++)
         send_poll(bdpc_pkg::time_type'(wall_ms +
                                        $urandom_range(0, live_cfg.debounce_ms / 2 + 1)),
                   i[0] ? !level : level);
      send_poll(bdpc_pkg::time_type'(wall_ms + $urandom_range(1, 9)), level);
      send_poll(bdpc_pkg::time_type'(wall_ms + live_cfg.debounce_ms + $urandom_range(0, 5)),
                level);
   endtask

   // A clean press: settle down, hold for a chosen time, settle up.
   task automatic press_episode();
      int unsigned hold_goal;
      int unsigned hold_polls;
      int unsigned stride;
      case ($urandom_range(0, 4))
         0: hold_goal = $urandom_range(0, live_cfg.short_press_max_ms);
         1: hold_goal = $urandom_range(live_cfg.short_press_max_ms, live_cfg.hold_short_ms);
         2: hold_goal = $urandom_range(live_cfg.hold_short_ms, live_cfg.hold_long_ms);
         3: hold_goal = live_cfg.hold_long_ms + $urandom_range(0, 3000);
         default: hold_goal = $urandom_range(0, 140000);
      endcase
      settle_to(1'b1);
      hold_polls = $urandom_range(1, 6);
      stride = hold_goal / hold_polls;
      repeat (hold_polls)
         send_poll(bdpc_pkg::time_type'(wall_ms + stride + $urandom_range(0, 2)), 1'b1);
      settle_to(1'b0);
   endtask

   // A few polls with random levels, some with timestamps anywhere in range.
   task automatic noise_burst();
      repeat ($urandom_range(1, 5))
         send_poll($urandom_range(0, 1) ? bdpc_pkg::time_type'($urandom)
                                        : bdpc_pkg::time_type'(wall_ms +
                                                               $urandom_range(0, 64)),
                   logic'($urandom_range(0, 1)));
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned stop_at;
      stop_at = polls_sent + quota;
      while (polls_sent < stop_at) begin
         if ($urandom_range(0, 3) != 0) press_episode();
         else noise_burst();
      end
   endtask

   // Result side: a random stall before each beat, and one long hold-off on request.
   initial begin
      int unsigned wait_cycles;
      rsp_stall     = 1'b0;
      receiver_calm = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_off_pending) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
         end
         if ($urandom_range(0, 39) == 0) receiver_calm = !receiver_calm;
         wait_cycles = receiver_calm ? 0 : $urandom_range(0, 9);
         if (wait_cycles != 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Main sequence.
   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_now_ms       = '0;
      req_raw_down     = 1'b0;
      csr_valid        = 1'b0;
      csr_index        = bdpc_pkg::CSR_DEBOUNCE_MS;
      csr_data         = '0;
      hold_off_pending = 1'b0;
      sender_calm      = 1'b0;
      polls_sent       = 0;
      wall_ms          = '0;
      live_cfg.debounce_ms        = bdpc_pkg::DEBOUNCE_MS_RESET;
      live_cfg.short_press_max_ms = bdpc_pkg::SHORT_PRESS_MAX_MS_RESET;
      live_cfg.hold_short_ms      = bdpc_pkg::HOLD_SHORT_MS_RESET;
      live_cfg.hold_long_ms       = bdpc_pkg::HOLD_LONG_MS_RESET;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Press that settles exactly at timestamp zero: no marks, held time zero.
      send_poll(32'hFFFF_FFA0, 1'b1);
      send_poll(32'd0, 1'b1);
      send_poll(32'd5000, 1'b1);
      send_poll(32'd5100, 1'b0);
      send_poll(32'd5200, 1'b0);
      // Too early, then settled on the debounce time; short mark on its threshold,
      // long mark later, release as hour setting.
      send_poll(32'd6000, 1'b1);
      send_poll(32'd6010, 1'b1);
      send_poll(32'd6030, 1'b1);
      send_poll(32'd8030, 1'b1);
      send_poll(32'd20000, 1'b1);
      send_poll(32'd20100, 1'b0);
      send_poll(32'd20130, 1'b0);
      // Single press.
      send_poll(32'd21000, 1'b1);
      send_poll(32'd21040, 1'b1);
      send_poll(32'd21100, 1'b0);
      send_poll(32'd21140, 1'b0);
      // Short mark, then release as breakpoint entry.
      send_poll(32'd22000, 1'b1);
      send_poll(32'd22030, 1'b1);
      send_poll(32'd24600, 1'b1);
      send_poll(32'd24610, 1'b0);
      send_poll(32'd24640, 1'b0);
      // Timestamps running backward: huge differences, both marks on successive polls.
      send_poll(32'd100, 1'b1);
      send_poll(32'd50, 1'b1);
      send_poll(32'd40, 1'b1);
      send_poll(32'd30, 1'b1);
      random_phase(300);

      // Small thresholds, with a long result-side hold-off.
      set_thresholds(16'd5, 16'd20, 16'd50, 16'd100, '1);
      hold_off_pending = 1'b1;
      random_phase(350);

      // All thresholds at zero.
      set_thresholds('0, '0, '0, '0,
                     bdpc_pkg::csr_index_type'($urandom_range(
                        bdpc_pkg::CSR_HOLD_LONG_MS + 1,
                        (1 << bdpc_pkg::CSR_INDEX_BITS) - 1)));
      random_phase(250);

      // All thresholds at their maximum.
      set_thresholds('1, '1, '1, '1,
                     bdpc_pkg::csr_index_type'($urandom_range(
                        bdpc_pkg::CSR_HOLD_LONG_MS + 1,
                        (1 << bdpc_pkg::CSR_INDEX_BITS) - 1)));
      random_phase(250);

      // Thresholds in reverse order.
      set_thresholds(16'd3, 16'd5000, 16'd900, 16'd300,
                     bdpc_pkg::csr_index_type'($urandom_range(
                        bdpc_pkg::CSR_HOLD_LONG_MS + 1,
                        (1 << bdpc_pkg::CSR_INDEX_BITS) - 1)));
      random_phase(300);

      // Random thresholds.
      set_thresholds(bdpc_pkg::cfg_word_type'($urandom_range(0, 200)),
                     bdpc_pkg::cfg_word_type'($urandom),
                     bdpc_pkg::cfg_word_type'($urandom),
                     bdpc_pkg::cfg_word_type'($urandom),
                     bdpc_pkg::csr_index_type'($urandom_range(
                        bdpc_pkg::CSR_HOLD_LONG_MS + 1,
                        (1 << bdpc_pkg::CSR_INDEX_BITS) - 1)));
      random_phase(300);

      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
